>>> rtl/ced_pkg.sv
`timescale 1ns / 1ps

package ced_pkg;

	// Most bytes one source character can produce (broken escape plus flush).
	localparam int MAX_BYTES = 3;
	localparam int CNT_W     = $clog2(MAX_BYTES + 1);
	localparam int IDX_W     = $clog2(MAX_BYTES);

	// Decoded-byte queue between front and back.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// One queue entry: the bytes decoded from one source character.
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [CNT_W-1:0]          count;
		logic                      eos;
	} entry_t;

endpackage

>>> rtl/ced_in_if.sv
`timescale 1ns / 1ps

interface ced_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_string;

	modport source (output valid, output in_char, output end_of_string, input ready);
	modport sink (input valid, input in_char, input end_of_string, output ready);
endinterface

>>> rtl/ced_out_if.sv
`timescale 1ns / 1ps

interface ced_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink (input valid, input out_byte, input last, output ready);
endinterface

>>> rtl/c_escape_string_decoder_unit.sv
`timescale 1ns / 1ps

// C escape-string decoder. Takes one source character per word on in_ch and
// emits decoded bytes on out_ch, last marking the final byte of a string. A
// character is accepted every cycle while the two-entry byte queue between
// the decoder front and the output side has room; a character that yields
// k bytes (0 to 3) is emitted as k output words at one byte per cycle while
// out_ready is high, so a run of multi-byte items slows input to that rate. An
// accepted character's bytes are registered in the queue before reaching out_ch.
module c_escape_string_decoder_unit (
	input  logic       clk,
	input  logic       arst_n,
	ced_in_if.sink     in_ch,
	ced_out_if.source  out_ch
);

	logic            q_full;
	logic            push;
	ced_pkg::entry_t push_entry;

	ced_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_ch.valid),
		.in_ready      (in_ch.ready),
		.in_char       (in_ch.in_char),
		.end_of_string (in_ch.end_of_string),
		.q_full        (q_full),
		.push          (push),
		.push_entry    (push_entry)
	);

	ced_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.q_full     (q_full),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.out_byte   (out_ch.out_byte),
		.last       (out_ch.last)
	);

endmodule

>>> rtl/ced_front.sv
`timescale 1ns / 1ps

module ced_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [7:0]      in_char,
	input  logic            end_of_string,
	input  logic            q_full,
	output logic            push,
	output ced_pkg::entry_t push_entry
);

	localparam logic [2:0] MODE_PLAIN  = 3'd0;
	localparam logic [2:0] MODE_BSLASH = 3'd1;
	localparam logic [2:0] MODE_OCT1   = 3'd2;
	localparam logic [2:0] MODE_OCT2   = 3'd3;
	localparam logic [2:0] MODE_HEXX   = 3'd4;
	localparam logic [2:0] MODE_HEX1   = 3'd5;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_THREE = 8'h33;
	localparam logic [7:0] CH_SEVEN = 8'h37;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_BSL   = 8'h5c;

	logic [2:0] mode_q, mode_d;
	logic [7:0] lead_q, lead_d;
	logic [7:0] second_q, second_d;

	logic [ced_pkg::MAX_BYTES-1:0][7:0] b;
	logic [ced_pkg::CNT_W-1:0]          n;
	logic                               accept;

	function automatic logic is_oct(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_SEVEN;
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return (c >= CH_ZERO && c <= CH_NINE) || (c >= 8'h61 && c <= 8'h66) ||
			(c >= 8'h41 && c <= 8'h46);
	endfunction

	// digits map by low nibble; letters a-f / A-F have low nibble 1..6
	function automatic logic [3:0] hex_val(input logic [7:0] c);
		return (c <= CH_NINE) ? c[3:0] : c[3:0] + 4'd9;
	endfunction

	function automatic logic [7:0] named(input logic [7:0] c);
		logic [7:0] r;
		case (c)
			8'h61: r = 8'd7;
			8'h62: r = 8'd8;
			8'h66: r = 8'd12;
			8'h6e: r = 8'd10;
			8'h72: r = 8'd13;
			8'h74: r = 8'd9;
			8'h76: r = 8'd11;
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic logic [7:0] lead_byte(input logic [7:0] l);
		return (l == CH_ZERO) ? 8'd0 : l;
	endfunction

	always_comb begin
		logic brk;
		brk      = 1'b0;
		b        = '0;
		n        = '0;
		mode_d   = mode_q;
		lead_d   = lead_q;
		second_d = second_q;
		case (mode_q)
			MODE_BSLASH: begin
				if (in_char >= CH_ZERO && in_char <= CH_THREE) begin
					lead_d = in_char;
					mode_d = MODE_OCT1;
				end else if (in_char == CH_X) begin
					mode_d = MODE_HEXX;
				end else begin
					b[n[ced_pkg::IDX_W-1:0]] = named(in_char);
					n = n + 1'b1;
					mode_d = MODE_PLAIN;
				end
			end
			MODE_OCT1: begin
				if (is_oct(in_char)) begin
					second_d = in_char;
					mode_d   = MODE_OCT2;
				end else begin
					b[n[ced_pkg::IDX_W-1:0]] = lead_byte(lead_q);
					n = n + 1'b1;
					brk = 1'b1;
				end
			end
			MODE_OCT2: begin
				if (is_oct(in_char)) begin
					b[n[ced_pkg::IDX_W-1:0]] = {lead_q[1:0], second_q[2:0], in_char[2:0]};
					n = n + 1'b1;
					mode_d = MODE_PLAIN;
				end else begin
					b[n[ced_pkg::IDX_W-1:0]] = lead_byte(lead_q);
					n = n + 1'b1;
					b[n[ced_pkg::IDX_W-1:0]] = second_q;
					n = n + 1'b1;
					brk = 1'b1;
				end
			end
			MODE_HEXX: begin
				if (is_hex(in_char)) begin
					lead_d = in_char;
					mode_d = MODE_HEX1;
				end else begin
					b[n[ced_pkg::IDX_W-1:0]] = CH_X;
					n = n + 1'b1;
					brk = 1'b1;
				end
			end
			MODE_HEX1: begin
				if (is_hex(in_char)) begin
					b[n[ced_pkg::IDX_W-1:0]] = {hex_val(lead_q), hex_val(in_char)};
					n = n + 1'b1;
					mode_d = MODE_PLAIN;
				end else begin
					b[n[ced_pkg::IDX_W-1:0]] = CH_X;
					n = n + 1'b1;
					b[n[ced_pkg::IDX_W-1:0]] = lead_q;
					n = n + 1'b1;
					brk = 1'b1;
				end
			end
			default: begin
				brk = 1'b1;
			end
		endcase

		// broken escape or plain mode: the character is decoded as plain text, or a backslash starts a new escape
		if (brk) begin
			if (in_char == CH_BSL) begin
				mode_d = MODE_BSLASH;
			end else begin
				b[n[ced_pkg::IDX_W-1:0]] = in_char;
				n = n + 1'b1;
				mode_d = MODE_PLAIN;
			end
		end

		// end of string: flush whatever escape is still pending
		if (end_of_string) begin
			case (mode_d)
				MODE_BSLASH: begin
					b[n[ced_pkg::IDX_W-1:0]] = CH_BSL;
					n = n + 1'b1;
				end
				MODE_OCT1: begin
					b[n[ced_pkg::IDX_W-1:0]] = lead_byte(lead_d);
					n = n + 1'b1;
				end
				MODE_OCT2: begin
					b[n[ced_pkg::IDX_W-1:0]] = lead_byte(lead_d);
					n = n + 1'b1;
					b[n[ced_pkg::IDX_W-1:0]] = second_d;
					n = n + 1'b1;
				end
				MODE_HEXX: begin
					b[n[ced_pkg::IDX_W-1:0]] = CH_X;
					n = n + 1'b1;
				end
				MODE_HEX1: begin
					b[n[ced_pkg::IDX_W-1:0]] = CH_X;
					n = n + 1'b1;
					b[n[ced_pkg::IDX_W-1:0]] = lead_d;
					n = n + 1'b1;
				end
				default: begin
				end
			endcase
			mode_d   = MODE_PLAIN;
			lead_d   = '0;
			second_d = '0;
		end
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign push     = accept && (n != '0);

	assign push_entry.bytes = b;
	assign push_entry.count = n;
	assign push_entry.eos   = end_of_string;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_PLAIN;
			lead_q   <= '0;
			second_q <= '0;
		end else if (accept) begin
			mode_q   <= mode_d;
			lead_q   <= lead_d;
			second_q <= second_d;
		end
	end

endmodule

>>> rtl/ced_back.sv
`timescale 1ns / 1ps

module ced_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ced_pkg::entry_t push_entry,
	output logic            q_full,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            last
);

	ced_pkg::entry_t q_mem [ced_pkg::QUEUE_DEPTH];

	logic [ced_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [ced_pkg::QCNT_W-1:0] cnt_q;
	logic [ced_pkg::IDX_W-1:0]  idx_q;
	ced_pkg::entry_t            head;
	logic                       final_byte;
	logic                       pop;

	function automatic logic [ced_pkg::QPTR_W-1:0] ptr_inc(
		input logic [ced_pkg::QPTR_W-1:0] p);
		return (p == ced_pkg::QPTR_W'(ced_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head       = q_mem[rd_ptr_q];
	assign final_byte = (ced_pkg::CNT_W'(idx_q) == head.count - 1'b1);
	assign q_full     = (cnt_q == ced_pkg::QCNT_W'(ced_pkg::QUEUE_DEPTH));
	assign out_valid  = (cnt_q != '0);
	assign out_byte   = head.bytes[idx_q];
	assign last       = head.eos && final_byte;
	assign pop        = out_valid && out_ready && final_byte;

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			idx_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
				idx_q    <= '0;
			end else if (out_valid && out_ready) begin
				idx_q <= idx_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/ced_checker.sv
`timescale 1ns / 1ps

module ced_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
		else $error("output word changed while stalled");

	// with nothing queued the front must be able to take a character
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty queue");

	// output only appears after a character was taken
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("output word without accepted input");

endmodule

bind c_escape_string_decoder_unit ced_checker u_ced_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.out_byte),
	.out_last  (out_ch.last)
);
